[hw/rtl/pfm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_pkg: shared constants and types of the perspective frustum matrix core
// Default word sizes, lane numbering and the per-item control word that
// travels from the front part through the queue to the back part.
// ----------------------------------------------------------------------------
package pfm_pkg;

  // Default sizes: Q16.16 in a 32-bit word
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned WORD_BITS_DEF = 32;

  // Number of divided terms and the lane of each
  localparam int unsigned NUM_TERMS   = 6;
  localparam int unsigned LANE_XSCALE = 0;
  localparam int unsigned LANE_YSCALE = 1;
  localparam int unsigned LANE_XOFF   = 2;
  localparam int unsigned LANE_YOFF   = 3;
  localparam int unsigned LANE_ZSCALE = 4;
  localparam int unsigned LANE_ZOFF   = 5;

  // Entries of the queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

  // Per-item control word
  typedef struct packed {
    logic [NUM_TERMS-1:0] neg;      // quotient sign per lane
    logic [NUM_TERMS-1:0] zero;     // zero denominator per lane
    logic                 infinite; // infinite-far form selected
    logic                 inf_sat;  // -2*near clamped
  } pfm_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/pfm_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_div: pipelined unsigned divider, one quotient bit per stage
// Checks for a quotient of more than WORD_BITS bits in the first stage, then
// restores one bit a stage. A new division may enter every cycle.
// ----------------------------------------------------------------------------
module pfm_div
  import pfm_pkg::*;
#(
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                   clk_i,
  input  wire logic [2*WORD_BITS:0]   num_i,
  input  wire logic [WORD_BITS:0]     den_i,
  output logic      [WORD_BITS-1:0]   quo_o,
  output logic                        ovf_o
);

  localparam int unsigned W = WORD_BITS;

  logic [W:0]   rem_q [W+1];
  logic [W:0]   den_q [W+1];
  logic [W-1:0] lo_q  [W+1];
  logic [W-1:0] quo_q [W+1];
  logic         ovf_q [W+1];

  logic [W:0] hi;
  logic       hi_ovf;

  // Flag a quotient that does not fit the low word
  assign hi     = num_i[2*W:W];
  assign hi_ovf = hi >= den_i;

  always_ff @(posedge clk_i) begin
    rem_q[0] <= hi_ovf ? '0 : hi;
    den_q[0] <= den_i;
    lo_q[0]  <= num_i[W-1:0];
    quo_q[0] <= '0;
    ovf_q[0] <= hi_ovf;
  end

  // Restore one quotient bit per stage
  for (genvar i = 1; i <= W; i++) begin : g_stage
    logic [W+1:0] trial;
    logic         ge;
    assign trial = {rem_q[i-1], lo_q[i-1][W-1]};
    assign ge    = trial >= {1'b0, den_q[i-1]};
    always_ff @(posedge clk_i) begin
      rem_q[i] <= ge ? (W+1)'(trial - {1'b0, den_q[i-1]}) : trial[W:0];
      den_q[i] <= den_q[i-1];
      lo_q[i]  <= {lo_q[i-1][W-2:0], 1'b0};
      quo_q[i] <= {quo_q[i-1][W-2:0], ge};
      ovf_q[i] <= ovf_q[i-1];
    end
  end

  assign quo_o = quo_q[W];
  assign ovf_o = ovf_q[W];

endmodule
`default_nettype wire

[hw/rtl/pfm_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_front: front part of the frustum matrix core
// Holds the infinity limit, forms denominators, numerator magnitudes and
// signs, the far*near product and the infinite-far depth offset.
// ----------------------------------------------------------------------------
module pfm_front
  import pfm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic signed [WORD_BITS-1:0]            cfg_data_i,
  input  wire logic signed [WORD_BITS-1:0]            left_plane_i,
  input  wire logic signed [WORD_BITS-1:0]            right_plane_i,
  input  wire logic signed [WORD_BITS-1:0]            bottom_plane_i,
  input  wire logic signed [WORD_BITS-1:0]            top_plane_i,
  input  wire logic signed [WORD_BITS-1:0]            near_distance_i,
  input  wire logic signed [WORD_BITS-1:0]            far_distance_i,
  output logic [NUM_TERMS-1:0][2*WORD_BITS:0]         num_o,
  output logic [NUM_TERMS-1:0][WORD_BITS:0]           den_o,
  output logic [WORD_BITS-1:0]                        inf_val_o,
  output pfm_ctl_t                                    ctl_o
);

  localparam int unsigned W  = WORD_BITS;
  localparam int unsigned NW = 2 * WORD_BITS + 1;

  logic signed [W-1:0] limit_q;

  logic signed [W:0]   dx, dy, dz;
  logic signed [W+1:0] sx, sy, sz, vinf;
  logic [W:0]          mdx, mdy, mdz, msx, msy, msz;
  logic [W-1:0]        mn, mf;
  logic [2*W-1:0]      prod;
  logic                pneg, sat_hi, sat_lo;

  // Take the infinity limit; writes must arrive only while idle, which the user keeps to: the block does not enforce it
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= {1'b0, {(W-1){1'b1}}};
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Differences and sums at full width
  assign dx = (W+1)'(right_plane_i) - (W+1)'(left_plane_i);
  assign dy = (W+1)'(top_plane_i) - (W+1)'(bottom_plane_i);
  assign dz = (W+1)'(far_distance_i) - (W+1)'(near_distance_i);
  assign sx = (W+2)'(right_plane_i) + (W+2)'(left_plane_i);
  assign sy = (W+2)'(top_plane_i) + (W+2)'(bottom_plane_i);
  assign sz = (W+2)'(0) - ((W+2)'(far_distance_i) + (W+2)'(near_distance_i));
  assign vinf = (W+2)'(0) - ((W+2)'(near_distance_i) + (W+2)'(near_distance_i));

  // Magnitudes
  assign mdx = dx[W] ? (W+1)'(-dx) : dx;
  assign mdy = dy[W] ? (W+1)'(-dy) : dy;
  assign mdz = dz[W] ? (W+1)'(-dz) : dz;
  assign msx = sx[W+1] ? (W+1)'(-sx) : sx[W:0];
  assign msy = sy[W+1] ? (W+1)'(-sy) : sy[W:0];
  assign msz = sz[W+1] ? (W+1)'(-sz) : sz[W:0];
  assign mn  = near_distance_i[W-1] ? W'(-near_distance_i) : near_distance_i;
  assign mf  = far_distance_i[W-1] ? W'(-far_distance_i) : far_distance_i;

  // Product for the finite depth offset, registered in the queue
  assign prod = (2*W)'(mf) * (2*W)'(mn);
  assign pneg = (far_distance_i != '0) && (near_distance_i != '0) &&
                (far_distance_i[W-1] == near_distance_i[W-1]);

  // Numerators
  assign num_o[LANE_XSCALE] = NW'(mn) << (FRAC_BITS + 1);
  assign num_o[LANE_YSCALE] = NW'(mn) << (FRAC_BITS + 1);
  assign num_o[LANE_XOFF]   = NW'(msx) << FRAC_BITS;
  assign num_o[LANE_YOFF]   = NW'(msy) << FRAC_BITS;
  assign num_o[LANE_ZSCALE] = NW'(msz) << FRAC_BITS;
  assign num_o[LANE_ZOFF]   = {prod, 1'b0};

  assign den_o[LANE_XSCALE] = mdx;
  assign den_o[LANE_YSCALE] = mdy;
  assign den_o[LANE_XOFF]   = mdx;
  assign den_o[LANE_YOFF]   = mdy;
  assign den_o[LANE_ZSCALE] = mdz;
  assign den_o[LANE_ZOFF]   = mdz;

  // Clamp -2*near for the infinite-far form
  assign sat_hi    = !vinf[W+1] && (vinf[W:W-1] != 2'b00);
  assign sat_lo    = vinf[W+1] && (vinf[W:W-1] != 2'b11);
  assign inf_val_o = sat_hi ? {1'b0, {(W-1){1'b1}}} :
                     sat_lo ? {1'b1, {(W-1){1'b0}}} : vinf[W-1:0];

  // Classify
  always_comb begin
    ctl_o.neg[LANE_XSCALE]  = near_distance_i[W-1] ^ dx[W];
    ctl_o.neg[LANE_YSCALE]  = near_distance_i[W-1] ^ dy[W];
    ctl_o.neg[LANE_XOFF]    = sx[W+1] ^ dx[W];
    ctl_o.neg[LANE_YOFF]    = sy[W+1] ^ dy[W];
    ctl_o.neg[LANE_ZSCALE]  = sz[W+1] ^ dz[W];
    ctl_o.neg[LANE_ZOFF]    = pneg ^ dz[W];
    ctl_o.zero[LANE_XSCALE] = (dx == '0);
    ctl_o.zero[LANE_YSCALE] = (dy == '0);
    ctl_o.zero[LANE_XOFF]   = (dx == '0);
    ctl_o.zero[LANE_YOFF]   = (dy == '0);
    ctl_o.zero[LANE_ZSCALE] = (dz == '0);
    ctl_o.zero[LANE_ZOFF]   = (dz == '0);
    ctl_o.infinite          = far_distance_i >= limit_q;
    ctl_o.inf_sat           = sat_hi || sat_lo;
  end

endmodule
`default_nettype wire

[hw/rtl/pfm_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_queue: short first-in first-out queue between front and back
// Registers each classified word; the back part drains one word a cycle.
// ----------------------------------------------------------------------------
module pfm_queue
  import pfm_pkg::*;
#(
  parameter int unsigned DATA_BITS = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire logic [DATA_BITS-1:0] data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output logic                      valid_o,
  output logic [DATA_BITS-1:0]      data_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic [DATA_BITS-1:0] mem_q [QUEUE_DEPTH];
  logic [AW-1:0]        wr_q, rd_q;
  logic [CW-1:0]        cnt_q;

  // Store the word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + AW'(1);
      end
      cnt_q <= cnt_q + CW'(push_i) - CW'(pop_i);
    end
  end

  assign full_o  = (cnt_q == CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(QUEUE_DEPTH))
    else $error("queue fill count beyond depth");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != '0)
    else $error("queue drained while empty");

endmodule
`default_nettype wire

[hw/rtl/pfm_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// pfm_back: back part of the frustum matrix core
// Six pipelined dividers with matching control delay, then sign, clamping,
// infinite-far selection and the degenerate flag into output registers.
// ----------------------------------------------------------------------------
module pfm_back
  import pfm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  input  wire logic [NUM_TERMS-1:0][2*WORD_BITS:0]    num_i,
  input  wire logic [NUM_TERMS-1:0][WORD_BITS:0]      den_i,
  input  wire logic [WORD_BITS-1:0]                   inf_val_i,
  input  wire pfm_ctl_t                               ctl_i,
  output logic                                        done_o,
  output logic [WORD_BITS-1:0]                        x_scale_o,
  output logic [WORD_BITS-1:0]                        y_scale_o,
  output logic [WORD_BITS-1:0]                        x_offset_o,
  output logic [WORD_BITS-1:0]                        y_offset_o,
  output logic [WORD_BITS-1:0]                        depth_scale_o,
  output logic [WORD_BITS-1:0]                        depth_offset_o,
  output logic                                        degenerate_o
);

  localparam int unsigned W = WORD_BITS;
  localparam logic [W-1:0] MAXV   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV   = {1'b1, {(W-1){1'b0}}};
  localparam logic [W-1:0] DS_INF = W'(0) - (W'(1) << FRAC_BITS);

  logic [NUM_TERMS-1:0][W-1:0] quo;
  logic [NUM_TERMS-1:0]        ovf;

  pfm_ctl_t     ctl_q [W+1];
  logic [W-1:0] iv_q  [W+1];
  logic         vld_q [W+1];

  logic [NUM_TERMS-1:0][W-1:0] res;
  logic [NUM_TERMS-1:0]        bad;
  logic                        flag;
  pfm_ctl_t                    c;

  logic [W-1:0] xs_q, ys_q, xo_q, yo_q, zs_q, zo_q;
  logic         deg_q, done_q;

  // Dividers
  for (genvar k = 0; k < NUM_TERMS; k++) begin : g_lane
    pfm_div #(
      .WORD_BITS(WORD_BITS)
    ) u_div (
      .clk_i (clk_i),
      .num_i (num_i[k]),
      .den_i (den_i[k]),
      .quo_o (quo[k]),
      .ovf_o (ovf[k])
    );
  end

  // Delay control alongside the dividers
  always_ff @(posedge clk_i) begin
    ctl_q[0] <= ctl_i;
    iv_q[0]  <= inf_val_i;
    for (int i = 1; i <= W; i++) begin
      ctl_q[i] <= ctl_q[i-1];
      iv_q[i]  <= iv_q[i-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= W; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      vld_q[0] <= in_valid_i;
      for (int i = 1; i <= W; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  // Apply sign and clamp per lane
  always_comb begin
    c = ctl_q[W];
    for (int k = 0; k < NUM_TERMS; k++) begin
      if (c.zero[k]) begin
        res[k] = '0;
        bad[k] = 1'b1;
      end else if (ovf[k] || (quo[k][W-1] && (!c.neg[k] || quo[k][W-2:0] != '0))) begin
        res[k] = c.neg[k] ? MINV : MAXV;
        bad[k] = 1'b1;
      end else begin
        res[k] = c.neg[k] ? W'(-quo[k]) : quo[k];
        bad[k] = 1'b0;
      end
    end
    if (c.infinite) begin
      flag = bad[LANE_XSCALE] | bad[LANE_YSCALE] | bad[LANE_XOFF] |
             bad[LANE_YOFF] | c.inf_sat;
    end else begin
      flag = |bad;
    end
  end

  // Register the result word
  always_ff @(posedge clk_i) begin
    xs_q  <= res[LANE_XSCALE];
    ys_q  <= res[LANE_YSCALE];
    xo_q  <= res[LANE_XOFF];
    yo_q  <= res[LANE_YOFF];
    zs_q  <= c.infinite ? DS_INF : res[LANE_ZSCALE];
    zo_q  <= c.infinite ? iv_q[W] : res[LANE_ZOFF];
    deg_q <= flag;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vld_q[W];
    end
  end

  assign done_o         = done_q;
  assign x_scale_o      = xs_q;
  assign y_scale_o      = ys_q;
  assign x_offset_o     = xo_q;
  assign y_offset_o     = yo_q;
  assign depth_scale_o  = zs_q;
  assign depth_offset_o = zo_q;
  assign degenerate_o   = deg_q;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(in_valid_i, W + 2))
    else $error("result word without matching item");

  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[W] && ctl_q[W].zero[LANE_XSCALE] |=> degenerate_o)
    else $error("zero width not flagged");

  a_inf_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[W] && ctl_q[W].infinite |=> depth_scale_o == DS_INF)
    else $error("infinite-far depth scale wrong");

endmodule
`default_nettype wire

[hw/rtl/perspective_frustum_matrix_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// perspective_frustum_matrix_core: perspective frustum projection terms
// Usage:
//   Raise start with the six plane fields; the word is taken at a clock edge
//   where start is high and busy is low. busy rises only when the two-entry
//   queue is full, which the back part never lets happen, so one word may be
//   taken every cycle.
//   Each result word appears for exactly one cycle with done_o high, after
//   its start has passed the queue, the dividers and the output registers.
//   The dividers restore one quotient bit per stage after an overflow check
//   stage; all six terms divide in parallel.
//   The receiver cannot stall; results leave in input order.
//   The infinity limit is written on the cfg channel (cfg_ready_o is always
//   high) while no word is in flight.
//   Reset clears the queue and the pipeline valids and sets the limit to the
//   largest positive value.
// ----------------------------------------------------------------------------
module perspective_frustum_matrix_core
  import pfm_pkg::*;
#(
  parameter int unsigned FRAC_BITS = FRAC_BITS_DEF,
  parameter int unsigned WORD_BITS = WORD_BITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic signed [WORD_BITS-1:0] left_plane_i,
  input  wire logic signed [WORD_BITS-1:0] right_plane_i,
  input  wire logic signed [WORD_BITS-1:0] bottom_plane_i,
  input  wire logic signed [WORD_BITS-1:0] top_plane_i,
  input  wire logic signed [WORD_BITS-1:0] near_distance_i,
  input  wire logic signed [WORD_BITS-1:0] far_distance_i,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic signed [WORD_BITS-1:0] cfg_data_i,
  output logic                             done_o,
  output logic signed [WORD_BITS-1:0]      x_scale_o,
  output logic signed [WORD_BITS-1:0]      y_scale_o,
  output logic signed [WORD_BITS-1:0]      x_offset_o,
  output logic signed [WORD_BITS-1:0]      y_offset_o,
  output logic signed [WORD_BITS-1:0]      depth_scale_o,
  output logic signed [WORD_BITS-1:0]      depth_offset_o,
  output logic                             degenerate_o
);

  localparam int unsigned W   = WORD_BITS;
  localparam int unsigned QWB = NUM_TERMS * (2*W + 1) + NUM_TERMS * (W + 1) + W +
                                $bits(pfm_ctl_t);

  logic [NUM_TERMS-1:0][2*W:0] f_num, b_num;
  logic [NUM_TERMS-1:0][W:0]   f_den, b_den;
  logic [W-1:0]                f_iv, b_iv;
  pfm_ctl_t                    f_ctl, b_ctl;
  logic                        push, full, q_valid;
  logic [QWB-1:0]              q_out;

  // Classify the incoming word
  pfm_front #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .left_plane_i    (left_plane_i),
    .right_plane_i   (right_plane_i),
    .bottom_plane_i  (bottom_plane_i),
    .top_plane_i     (top_plane_i),
    .near_distance_i (near_distance_i),
    .far_distance_i  (far_distance_i),
    .num_o           (f_num),
    .den_o           (f_den),
    .inf_val_o       (f_iv),
    .ctl_o           (f_ctl)
  );

  assign push = start && !full;
  assign busy = full;

  // Queue between front and back
  pfm_queue #(
    .DATA_BITS(QWB)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  ({f_num, f_den, f_iv, f_ctl}),
    .full_o  (full),
    .pop_i   (q_valid),
    .valid_o (q_valid),
    .data_o  (q_out)
  );

  assign {b_num, b_den, b_iv, b_ctl} = q_out;

  // Divide, clamp and deliver
  pfm_back #(
    .FRAC_BITS(FRAC_BITS),
    .WORD_BITS(WORD_BITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (q_valid),
    .num_i          (b_num),
    .den_i          (b_den),
    .inf_val_i      (b_iv),
    .ctl_i          (b_ctl),
    .done_o         (done_o),
    .x_scale_o      (x_scale_o),
    .y_scale_o      (y_scale_o),
    .x_offset_o     (x_offset_o),
    .y_offset_o     (y_offset_o),
    .depth_scale_o  (depth_scale_o),
    .depth_offset_o (depth_offset_o),
    .degenerate_o   (degenerate_o)
  );

endmodule
`default_nettype wire

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Perspective frustum matrix core testbench
// Drives frustum words through the command port, predicts the six projection
// terms and the degenerate flag in wide integer arithmetic, and checks every
// result word in order. Runs several infinity-limit settings, extremes among
// them, with random sender gaps.
// ----------------------------------------------------------------------------
module testbench
  import pfm_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = FRAC_BITS_DEF;
  localparam int WB = WORD_BITS_DEF;
  localparam int LATENCY = WB + 3;

  typedef logic signed [WB-1:0] word_t;

  typedef struct {
    word_t xs, ys, xo, yo, zs, zo;
    logic  degen;
  } frustum_terms_t;

  // Predict the projection terms and check result words in order
  class frustum_scoreboard;
    frustum_terms_t pending[$];
    word_t          inf_limit;
    int             errors;

    function new();
      inf_limit = {1'b0, {(WB-1){1'b1}}};
      errors    = 0;
    endfunction

    // Clamp a signed quotient to the word range, flag on clamp
    function automatic word_t sat(logic signed [191:0] v, ref logic flag);
      logic signed [191:0] hi, lo;
      hi = (192'sd1 <<< (WB-1)) - 1;
      lo = -(192'sd1 <<< (WB-1));
      if (v > hi) begin
        flag = 1'b1;
        return hi[WB-1:0];
      end
      if (v < lo) begin
        flag = 1'b1;
        return lo[WB-1:0];
      end
      return v[WB-1:0];
    endfunction

    // Truncating division; a zero denominator gives 0 and sets the flag
    function automatic word_t divide(logic signed [191:0] num,
                                     logic signed [191:0] den, ref logic flag);
      if (den == 0) begin
        flag = 1'b1;
        return '0;
      end
      return sat(num / den, flag);
    endfunction

    function void note_frustum(word_t l, word_t r, word_t b, word_t t,
                               word_t n, word_t f);
      frustum_terms_t e;
      logic flag;
      logic signed [191:0] wl, wr, wb, wt, wn, wf;
      flag = 1'b0;
      wl = l; wr = r; wb = b; wt = t; wn = n; wf = f;
      e.xs = divide(wn <<< (FB+1), wr - wl, flag);
      e.ys = divide(wn <<< (FB+1), wt - wb, flag);
      e.xo = divide((wr + wl) <<< FB, wr - wl, flag);
      e.yo = divide((wt + wb) <<< FB, wt - wb, flag);
      if (f >= inf_limit) begin
        e.zs = -(word_t'(1) <<< FB);
        e.zo = sat(-2 * wn, flag);
      end else begin
        e.zs = divide(-(wf + wn) <<< FB, wf - wn, flag);
        e.zo = divide(-2 * wf * wn, wf - wn, flag);
      end
      e.degen = flag;
      pending.push_back(e);
    endfunction

    function void check_terms(frustum_terms_t a);
      frustum_terms_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result word xs=%h", $realtime, a.xs);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (a.xs !== e.xs) report_field("x_scale", e.xs, a.xs);
      if (a.ys !== e.ys) report_field("y_scale", e.ys, a.ys);
      if (a.xo !== e.xo) report_field("x_offset", e.xo, a.xo);
      if (a.yo !== e.yo) report_field("y_offset", e.yo, a.yo);
      if (a.zs !== e.zs) report_field("depth_scale", e.zs, a.zs);
      if (a.zo !== e.zo) report_field("depth_offset", e.zo, a.zo);
      if (a.degen !== e.degen) report_field("degenerate", e.degen, a.degen);
    endfunction

    function void report_field(string name, word_t e, word_t a);
      $display("%0t: %s mismatch expected %h actual %h", $realtime, name, e, a);
      errors++;
    endfunction
  endclass

  logic  clk_i = 1'b0;
  logic  rst_ni = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  word_t left_q = '0, right_q = '0, bottom_q = '0, top_q = '0;
  word_t near_q = '0, far_q = '0;
  logic  cfg_valid_q = 1'b0;
  logic  cfg_ready;
  word_t cfg_data_q = '0;
  logic  done;
  word_t xs, ys, xo, yo, zs, zo;
  logic  degen;

  frustum_scoreboard sb = new();
  int idle_pct = 0;

  perspective_frustum_matrix_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .left_plane_i   (left_q),
    .right_plane_i  (right_q),
    .bottom_plane_i (bottom_q),
    .top_plane_i    (top_q),
    .near_distance_i(near_q),
    .far_distance_i (far_q),
    .cfg_valid_i    (cfg_valid_q),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data_q),
    .done_o         (done),
    .x_scale_o      (xs),
    .y_scale_o      (ys),
    .x_offset_o     (xo),
    .y_offset_o     (yo),
    .depth_scale_o  (zs),
    .depth_offset_o (zo),
    .degenerate_o   (degen)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Take each result word at the edge that ends its cycle
  always @(posedge clk_i) begin
    frustum_terms_t a;
    if (rst_ni && done) begin
      a.xs = xs; a.ys = ys; a.xo = xo; a.yo = yo;
      a.zs = zs; a.zo = zo; a.degen = degen;
      sb.check_terms(a);
    end
  end

  // Send one frustum word, with a random gap in front of it
  task automatic send_frustum(word_t l, word_t r, word_t b, word_t t,
                              word_t n, word_t f);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    left_q <= l; right_q <= r; bottom_q <= b; top_q <= t;
    near_q <= n; far_q <= f;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_frustum(l, r, b, t, n, f);
  endtask

  // Drain in-flight words, then write the infinity limit
  task automatic write_limit(word_t v);
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    cfg_valid_q <= 1'b1;
    cfg_data_q  <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid_q <= 1'b0;
    sb.inf_limit = v;
  endtask

  function automatic word_t rnd_word();
    case ($urandom_range(5))
      0: return $urandom();
      1: return word_t'($urandom_range(8)) - 4;
      2: return $urandom_range(1) ? {1'b0, {(WB-1){1'b1}}} : {1'b1, {(WB-1){1'b0}}};
      default: return word_t'(int'($urandom_range(20 << FB)) - (10 << FB));
    endcase
  endfunction

  // Mostly sensible frusta with random content, some raw noise
  task automatic send_random();
    word_t l, r, b, t, n, f;
    if ($urandom_range(3) == 0) begin
      send_frustum(rnd_word(), rnd_word(), rnd_word(), rnd_word(),
                   rnd_word(), rnd_word());
    end else begin
      l = -word_t'($urandom_range(4 << FB));
      r = $urandom_range(4 << FB);
      b = -word_t'($urandom_range(4 << FB));
      t = $urandom_range(4 << FB);
      n = $urandom_range(1, 2 << FB);
      f = n + word_t'($urandom_range(1000 << FB));
      send_frustum(l, r, b, t, n, f);
    end
  endtask

  localparam word_t MAXW = {1'b0, {(WB-1){1'b1}}};
  localparam word_t MINW = {1'b1, {(WB-1){1'b0}}};
  localparam word_t ONE  = word_t'(1) <<< FB;

  initial begin
    int phase;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, zero denominators, saturation, infinite far
    send_frustum(-ONE, ONE, -ONE, ONE, ONE, 100 * ONE);
    send_frustum(ONE, ONE, ONE, ONE, ONE, ONE);
    send_frustum(MINW, MAXW, MINW, MAXW, MAXW, MINW);
    send_frustum(MAXW, MINW, MAXW, MINW, MINW, MAXW);
    send_frustum(0, 1, 0, 1, MAXW, MAXW);
    send_frustum(-1, 0, -1, 0, MINW, 0);
    send_frustum(MAXW, MAXW, MINW, MINW, 0, 0);
    send_frustum('1, '0, '0, '1, '1, '0);
    send_frustum(-2 * ONE, ONE, -ONE, 3 * ONE, ONE >> 4, 1000 * ONE);
    write_limit(100 * ONE);
    send_frustum(-ONE, ONE, -ONE, ONE, ONE, 100 * ONE);
    send_frustum(-ONE, ONE, -ONE, ONE, MINW, 200 * ONE);
    send_frustum(-ONE, ONE, -ONE, ONE, MAXW, MAXW);
    send_frustum(-ONE, ONE, -ONE, ONE, ONE, 99 * ONE);
    write_limit(MINW);
    send_frustum(-ONE, ONE, -ONE, ONE, MINW, MINW);
    send_frustum(-ONE, ONE, -ONE, ONE, 5, 5);
    write_limit(0);
    send_frustum(-ONE, ONE, -ONE, ONE, ONE, -1);
    send_frustum(-ONE, ONE, -ONE, ONE, ONE, 0);

    // Random: sender gaps, then no gaps; limit changes between phases
    for (phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 27 : (phase == 1) ? 59 : 0;
      write_limit(phase == 0 ? MAXW : phase == 1 ? 500 * ONE : rnd_word());
      repeat (180) send_random();
    end
    start <= 1'b0;

    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
    if (sb.errors == 0)
      $display("perspective_frustum_matrix_core verification clean");
    else
      $display("perspective_frustum_matrix_core verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("perspective_frustum_matrix_core verification failed");
    $finish;
  end

endmodule
